/* src/hppt_pkg.sv */
`default_nettype none
package hppt_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_POINT  = 2'd1,
    ACT_PERSP  = 2'd2,
    ACT_PLANE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [1:0] MAT_SRC_FWD = 2'd0;
  localparam logic [1:0] MAT_SRC_INV = 2'd1;
  localparam logic [1:0] MAT_TGT_FWD = 2'd2;
  localparam logic [1:0] MAT_TGT_INV = 2'd3;

endpackage
`default_nettype wire

/* src/hppt_if.sv */
`default_nettype none
interface hppt_in_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [1:0]   action;
  logic [5:0]   coef_index;
  logic [W-1:0] coef_value;
  logic         use_source;
  logic         use_target;
  logic [W-1:0] x_in;
  logic [W-1:0] y_in;
  logic [W-1:0] z_in;
  logic [W-1:0] w_in;
  modport source (output valid, action, coef_index, coef_value, use_source, use_target,
                  x_in, y_in, z_in, w_in, input ready);
  modport sink (input valid, action, coef_index, coef_value, use_source, use_target,
                x_in, y_in, z_in, w_in, output ready);
endinterface

interface hppt_out_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] x_out;
  logic [W-1:0] y_out;
  logic [W-1:0] z_out;
  logic [W-1:0] w_out;
  logic         overflowed;
  modport source (output valid, x_out, y_out, z_out, w_out, overflowed, input ready);
  modport sink (input valid, x_out, y_out, z_out, w_out, overflowed, output ready);
endinterface
`default_nettype wire

/* src/hppt_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle, result saturated to W bits
module hppt_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] den_i,
  output logic              done_o,
  output logic [W-1:0]      quo_o,
  output logic              ovf_o
);
  localparam int unsigned NB = W + F;
  localparam int unsigned CB = $clog2(NB + 1);

  logic [NB-1:0] num_q, num_d;
  logic [NB-1:0] quo_q, quo_d;
  logic [W:0]    rem_q, rem_d;
  logic [W-1:0]  den_q, den_d;
  logic          neg_q, neg_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [W:0]    shl;
  logic [W:0]    sub;
  logic [NB:0]   sq;
  logic [W-1:0]  na, da;

  always_comb begin
    na = num_i[W-1] ? (~num_i + 1'b1) : num_i;
    da = den_i[W-1] ? (~den_i + 1'b1) : den_i;
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q; neg_d = neg_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    shl = {rem_q[W-1:0], num_q[NB-1]};
    sub = shl - {1'b0, den_q};
    if (start_i) begin
      num_d = NB'(na) << F;
      den_d = da;
      neg_d = num_i[W-1] ^ den_i[W-1];
      rem_d = '0;
      quo_d = '0;
      cnt_d = CB'(NB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (shl >= {1'b0, den_q}) begin
        rem_d = sub;
        quo_d = {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_d = shl;
        quo_d = {quo_q[NB-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  // signed saturation of the magnitude quotient
  always_comb begin
    sq = neg_q ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};
    ovf_o = 1'b0;
    quo_o = sq[W-1:0];
    if (sq[NB:W-1] != {(NB-W+2){1'b0}} && sq[NB:W-1] != {(NB-W+2){1'b1}}) begin
      ovf_o = 1'b1;
      quo_o = sq[NB] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

/* src/homogeneous_point_plane_transform.sv */
// a load beat is taken one per cycle while idle with no result pending; a point or plane
// result passes through S enabled matrix stages (0 to 2) of 16 store reads each, and
// a perspective action then divides x, y and z by w in turn when w is nonzero
// throughput: one transform at a time, input reopens the cycle after the result beat is taken
// coefficient store is a 64-entry memory with one registered read port; no reset, it
// must be loaded before use; rst_ni clears all control state asynchronously
`default_nettype none
module homogeneous_point_plane_transform import hppt_pkg::*; #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  hppt_in_if.sink   in_i,
  hppt_out_if.source out_o
);
  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned PW = 2 * COORD_BITS;

  state_e       st_q, st_d;
  logic [W-1:0] mem [64];
  logic [W-1:0] rd_q;
  logic [W-1:0] v_q [4];
  logic [W-1:0] t_q [4];
  logic [W-1:0] acc_q;
  logic [1:0]   act_q;
  logic         src_q, tgt_q, ovf_q;
  logic         stg_q;          // 0 first stage, 1 second
  logic [4:0]   k_q;            // issue counter, 16 reads plus one drain
  logic         rv_q;           // read data valid
  logic [3:0]   ki_q;           // index of the beat in rd_q
  logic [1:0]   dn_q;           // divide lane
  logic         ovalid_q;
  logic [W-1:0] o_q [4];
  logic         oovf_q;

  logic         run_tgt;
  logic [1:0]   mat;
  logic         transp;
  logic [5:0]   raddr;
  logic [W-1:0] vc;
  logic [PW-1:0] prod;
  logic [W-1:0] sat_v;
  logic         sat_o;
  logic         div_start, div_done, div_ovf;
  logic [W-1:0] div_q;
  logic [W-1:0] div_num;
  logic         accept;
  logic         persp_go;

  assign accept = in_i.valid & in_i.ready;
  assign in_i.ready = (st_q == ST_IDLE) && !ovalid_q;

  // which matrix and orientation this stage uses
  always_comb begin
    run_tgt = tgt_q;
    if (act_q == ACT_PLANE) begin
      mat = stg_q ? MAT_TGT_FWD : MAT_SRC_INV;
      transp = 1'b1;
    end else begin
      mat = stg_q ? MAT_TGT_INV : MAT_SRC_FWD;
      transp = 1'b0;
    end
    raddr = transp ? {mat, k_q[1:0], k_q[3:2]} : {mat, k_q[3:0]};
  end

  // one multiply of stored coefficient by the input component, truncated
  assign vc = v_q[ki_q[1:0]];
  assign prod = $signed({{W{rd_q[W-1]}}, rd_q}) * $signed({{W{vc[W-1]}}, vc});
  always_comb begin
    logic [PW-1:0] term;
    logic [PW:0]   s;
    term = PW'($signed(prod) >>> FRACTION_BITS);
    s = {{(PW-W+1){acc_q[W-1]}}, acc_q} + {term[PW-1], term};
    sat_o = 1'b0;
    sat_v = s[W-1:0];
    if (s[PW:W-1] != {(PW-W+2){1'b0}} && s[PW:W-1] != {(PW-W+2){1'b1}}) begin
      sat_o = 1'b1;
      sat_v = s[PW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  assign persp_go = (act_q == ACT_PERSP) && (v_q[3] != '0);

  // a restart on done takes the next lane
  assign div_num = div_done ? v_q[dn_q + 2'd1] : v_q[dn_q];

  hppt_div #(.W(W), .F(FRACTION_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i(div_num),
    .den_i(v_q[3]),
    .done_o(div_done),
    .quo_o(div_q),
    .ovf_o(div_ovf)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept && in_i.action != ACT_LOAD) begin
        if (in_i.use_source || in_i.use_target) st_d = ST_MAC;
        else st_d = ST_DIV;
      end
      ST_MAC: if (rv_q && ki_q == 4'd15 && (stg_q || !run_tgt)) st_d = ST_DIV;
      ST_DIV: if (!persp_go || (div_done && dn_q == 2'd2)) st_d = ST_OUT;
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    if (st_q == ST_DIV && persp_go && (k_q == 5'd0 || div_done) && !(div_done && dn_q == 2'd2))
      div_start = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.action == ACT_LOAD) mem[in_i.coef_index] <= in_i.coef_value;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ovalid_q <= 1'b0;
      rv_q <= 1'b0;
      k_q <= '0;
      stg_q <= 1'b0;
      dn_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_OUT) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
      rv_q <= (st_q == ST_MAC) && (k_q < 5'd16);
      if (accept) begin
        k_q <= '0;
        stg_q <= !in_i.use_source;
        dn_q <= '0;
      end else if (st_q == ST_MAC) begin
        if (rv_q && ki_q == 4'd15) begin
          k_q <= '0;
          stg_q <= 1'b1;
        end else if (k_q < 5'd16) begin
          k_q <= k_q + 1'b1;
        end
      end else if (st_q == ST_DIV) begin
        if (k_q == 5'd0) k_q <= 5'd1;
        if (div_done) dn_q <= dn_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ki_q <= k_q[3:0];
    if (accept) begin
      act_q <= in_i.action;
      src_q <= in_i.use_source;
      tgt_q <= in_i.use_target;
      ovf_q <= 1'b0;
      acc_q <= '0;
      v_q[0] <= in_i.x_in; v_q[1] <= in_i.y_in;
      v_q[2] <= in_i.z_in; v_q[3] <= in_i.w_in;
    end else if (st_q == ST_MAC && rv_q) begin
      if (sat_o) ovf_q <= 1'b1;
      if (ki_q[1:0] == 2'd3) begin
        t_q[ki_q[3:2]] <= sat_v;
        acc_q <= '0;
        if (ki_q == 4'd15) begin
          v_q[0] <= t_q[0]; v_q[1] <= t_q[1]; v_q[2] <= t_q[2]; v_q[3] <= sat_v;
        end
      end else begin
        acc_q <= sat_v;
      end
    end else if (st_q == ST_DIV && div_done) begin
      if (div_ovf) ovf_q <= 1'b1;
      t_q[dn_q] <= div_q;
    end
    if (st_q == ST_OUT) begin
      o_q[0] <= persp_go ? t_q[0] : v_q[0];
      o_q[1] <= persp_go ? t_q[1] : v_q[1];
      o_q[2] <= persp_go ? t_q[2] : v_q[2];
      if (persp_go && FRACTION_BITS >= W - 1) begin
        o_q[3] <= {1'b0, {(W-1){1'b1}}};
        oovf_q <= 1'b1;
      end else begin
        o_q[3] <= persp_go ? (W'(1) << FRACTION_BITS) : v_q[3];
        oovf_q <= ovf_q;
      end
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.x_out = o_q[0];
  assign out_o.y_out = o_q[1];
  assign out_o.z_out = o_q[2];
  assign out_o.w_out = o_q[3];
  assign out_o.overflowed = oovf_q;
endmodule
`default_nettype wire

/* src/hppt_checker.sv */
`default_nettype none
module hppt_checker import hppt_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic [1:0] in_action_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  // output beat holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("output dropped");
  // no new item while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("ready with pending result");
  // an accepted transform closes input for the next cycle
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i != ACT_LOAD |=> !in_ready_i)
    else $error("input reopened early");
  // a result never shows right after a load
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_action_i == ACT_LOAD && !out_valid_i |=> !out_valid_i)
    else $error("load produced a result");
endmodule

bind homogeneous_point_plane_transform hppt_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_i.valid), .in_ready_i(in_i.ready), .in_action_i(in_i.action),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready)
);
`default_nettype wire
